/* rtl/srit_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srit_pkg
// Shared types, codes and helpers for the sorted record insert table.
// ----------------------------------------------------------------------------
package srit_pkg;

    localparam int DEF_CAPACITY = 256;
    localparam int NAME_BYTES   = 20;
    localparam int FIELD_BYTES  = 20;
    localparam int NAME_BITS    = 8 * FIELD_BYTES;
    localparam int HEAD_W       = 64;
    localparam int MIDDLE_W     = 64;
    localparam int TAIL_W       = 32;
    localparam int POP_W        = 31;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int POS_W        = 8;
    localparam int COUNT_W      = 9;
    localparam int SEL_LO_W     = 4;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [HEAD_W-1:0]   name_head;
        logic [MIDDLE_W-1:0] name_middle;
        logic [TAIL_W-1:0]   name_tail;
        logic [POP_W-1:0]    population;
    } t_rec;

    typedef struct packed {
        t_rec rec;
        logic valid;
        logic gt;
    } t_link;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic clr;
    } t_cell_ctl;

    // Width of the padded read index: at least one low group and two groups.
    function automatic int sel_idx_w(input int cap);
        int w;
        w = $clog2(cap);
        return (w > SEL_LO_W + 1) ? w : SEL_LO_W + 1;
    endfunction

    // Sort key of a name: bytes after the first zero byte and bytes beyond
    // the compared length are cleared, so a plain unsigned compare matches
    // the string order.
    function automatic logic [NAME_BITS-1:0] name_key(input t_rec rec);
        logic [NAME_BITS-1:0] word;
        logic [NAME_BITS-1:0] key;
        logic                 ended;
        logic [7:0]           b;
        word  = {rec.name_head, rec.name_middle, rec.name_tail};
        key   = '0;
        ended = 1'b0;
        for (int i = 0; i < FIELD_BYTES; i++) begin
            b = word[NAME_BITS-1-8*i -: 8];
            if (i >= NAME_BYTES) begin
                ended = 1'b1;
            end
            if (!ended) begin
                key[NAME_BITS-1-8*i -: 8] = b;
            end
            if (b == 8'h00) begin
                ended = 1'b1;
            end
        end
        return key;
    endfunction

endpackage

/* rtl/srit_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srit_in_if / srit_out_if
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface srit_in_if;
    import srit_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [HEAD_W-1:0]   name_head;
    logic [MIDDLE_W-1:0] name_middle;
    logic [TAIL_W-1:0]   name_tail;
    logic [POP_W-1:0]    population;
    logic [POS_W-1:0]    read_index;

    modport source (
        output valid, kind, name_head, name_middle, name_tail, population, read_index,
        input  ready
    );
    modport sink (
        input  valid, kind, name_head, name_middle, name_tail, population, read_index,
        output ready
    );
endinterface

interface srit_out_if;
    import srit_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  entry_count;
    logic [HEAD_W-1:0]   out_name_head;
    logic [MIDDLE_W-1:0] out_name_middle;
    logic [TAIL_W-1:0]   out_name_tail;
    logic [POP_W-1:0]    out_population;

    modport source (
        output valid, status, position, entry_count, out_name_head, out_name_middle,
               out_name_tail, out_population,
        input  ready
    );
    modport sink (
        input  valid, status, position, entry_count, out_name_head, out_name_middle,
               out_name_tail, out_population,
        output ready
    );
endinterface

/* rtl/srit_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srit_cell
// One table slot: compares its record with the new one and shifts right.
// ----------------------------------------------------------------------------
module srit_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srit_pkg::t_cell_ctl               i_ctl,
    input  srit_pkg::t_rec                    i_new,
    input  logic [srit_pkg::NAME_BITS-1:0]    i_new_key,
    input  srit_pkg::t_link                   i_prev,
    output srit_pkg::t_link                   o_link,
    output logic                              o_take
);
    import srit_pkg::*;

    t_rec r_rec;
    logic r_valid;
    logic r_gt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_gt    <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_gt <= r_valid &&
                        ({name_key(r_rec), r_rec.population} > {i_new_key, i_new.population});
            end
            if (i_ctl.ins) begin
                r_valid <= r_valid | i_prev.valid;
            end else if (i_ctl.clr) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (r_gt || !r_valid) begin
                r_rec <= i_prev.gt ? i_prev.rec : i_new;
            end
        end
    end

    assign o_link = '{rec: r_rec, valid: r_valid, gt: r_gt};
    assign o_take = i_prev.valid && !i_prev.gt && (r_gt || !r_valid);

endmodule

/* rtl/srit_read_sel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srit_read_sel
// Two-level registered selector that picks one slot of the cell row.
// ----------------------------------------------------------------------------
module srit_read_sel #(
    parameter int CAPACITY = srit_pkg::DEF_CAPACITY
) (
    input  logic                                        i_clk,
    input  srit_pkg::t_rec                              i_recs [CAPACITY],
    input  logic [srit_pkg::sel_idx_w(CAPACITY)-1:0]    i_idx,
    input  logic                                        i_load_grp,
    input  logic                                        i_load_out,
    output srit_pkg::t_rec                              o_rec
);
    import srit_pkg::*;

    localparam int IW   = sel_idx_w(CAPACITY);
    localparam int PADN = 2 ** IW;
    localparam int NG   = 2 ** (IW - SEL_LO_W);

    t_rec w_pad [PADN];
    t_rec r_grp [NG];
    t_rec r_rec;

    genvar g;
    for (g = 0; g < PADN; g++) begin : g_pad
        if (g < CAPACITY) begin : g_used
            assign w_pad[g] = i_recs[g];
        end else begin : g_fill
            assign w_pad[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_grp) begin
            for (int k = 0; k < NG; k++) begin
                r_grp[k] <= w_pad[{(IW-SEL_LO_W)'(k), i_idx[SEL_LO_W-1:0]}];
            end
        end
        if (i_load_out) begin
            r_rec <= r_grp[i_idx[IW-1:SEL_LO_W]];
        end
    end

    assign o_rec = r_rec;

endmodule

/* rtl/sorted_record_insert_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_record_insert_table_unit
// Table of records kept sorted by name and population in a row of cells.
// ----------------------------------------------------------------------------
// Requests arrive as beats on i_req: insert a record, read the slot given by
// read_index, or clear the table. Every request gives exactly one response
// beat on o_rsp with a status, the slot touched and the entry count.
// Each slot is a cell holding one record. An insert is done by all cells at
// once: every cell compares its record against the new one, then empty
// cells and cells holding greater records take their left neighbor's
// record or the new one. A read goes through a two-level registered
// selector over the cells. A request passes through accept, compare,
// update, and result steps. The next request is taken in the cycle after
// the response of the last one is loaded, so a request is not accepted
// while the one before it is still in its steps.
// The response sits in an output register; if the receiver stalls, a new
// request is still accepted and processed, and it waits in its result step
// until the output register frees.
// Reset empties the table at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module sorted_record_insert_table_unit #(
    parameter int CAPACITY = srit_pkg::DEF_CAPACITY
) (
    input logic        i_clk,
    input logic        i_rst_n,
    srit_in_if.sink    i_req,
    srit_out_if.source o_rsp
);
    import srit_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PW   = $clog2(CAPACITY);
    localparam int IW   = sel_idx_w(CAPACITY);
    localparam int CMPW = CW + POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [KIND_W-1:0]   r_kind;
    t_rec                r_item;
    logic [POS_W-1:0]    r_idx;
    logic [CW-1:0]       r_count;
    logic                r_full;
    logic                r_beyond;
    logic [CAPACITY-1:0] r_take;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [POS_W-1:0]    r_position;
    logic [COUNT_W-1:0]  r_entry_count;
    t_rec                r_out_rec;

    t_cell_ctl             w_ctl;
    logic [NAME_BITS-1:0]  w_new_key;
    t_link                 w_link [CAPACITY];
    t_link                 w_prev [CAPACITY];
    t_rec                  w_recs [CAPACITY];
    logic [CAPACITY-1:0]   w_take;
    logic [PW-1:0]         w_pos;
    t_rec                  w_sel_rec;
    logic                  w_out_free;

    assign w_new_key  = name_key(r_item);
    assign w_ctl.cmp  = (r_state == S_CMP);
    assign w_ctl.ins  = (r_state == S_UPD) && (r_kind == KIND_INSERT) && !r_full;
    assign w_ctl.clr  = (r_state == S_UPD) && (r_kind == KIND_CLEAR);
    assign w_out_free = !r_out_valid || o_rsp.ready;

    genvar g;
    for (g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev[g] = '{rec: '0, valid: 1'b1, gt: 1'b0};
        end else begin : g_rest
            assign w_prev[g] = w_link[g-1];
        end

        srit_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_new     (r_item),
            .i_new_key (w_new_key),
            .i_prev    (w_prev[g]),
            .o_link    (w_link[g]),
            .o_take    (w_take[g])
        );

        assign w_recs[g] = w_link[g].rec;
    end

    srit_read_sel #(
        .CAPACITY (CAPACITY)
    ) u_read_sel (
        .i_clk      (i_clk),
        .i_recs     (w_recs),
        .i_idx      (IW'(r_idx)),
        .i_load_grp (r_state == S_CMP),
        .i_load_out (r_state == S_UPD),
        .o_rec      (w_sel_rec)
    );

    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (r_take[i]) begin
                w_pos = w_pos | PW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_take      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_kind                <= i_req.kind;
                        r_item.name_head      <= i_req.name_head;
                        r_item.name_middle    <= i_req.name_middle;
                        r_item.name_tail      <= i_req.name_tail;
                        r_item.population     <= i_req.population;
                        r_idx                 <= i_req.read_index;
                        r_state               <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_full   <= (r_count == CW'(CAPACITY));
                    r_beyond <= (CMPW'(r_idx) >= CMPW'(r_count));
                    r_state  <= S_UPD;
                end
                S_UPD: begin
                    if (w_ctl.ins) begin
                        r_take  <= w_take;
                        r_count <= r_count + 1'b1;
                    end else if (w_ctl.clr) begin
                        r_count <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_entry_count <= COUNT_W'(r_count);
                        case (r_kind)
                            KIND_INSERT: begin
                                r_status   <= r_full ? ST_FULL : ST_OK;
                                r_position <= r_full ? '0 : POS_W'(w_pos);
                                r_out_rec  <= '0;
                            end
                            KIND_READ: begin
                                r_status   <= r_beyond ? ST_RANGE : ST_OK;
                                r_position <= r_idx;
                                r_out_rec  <= r_beyond ? t_rec'('0) : w_sel_rec;
                            end
                            default: begin
                                r_status   <= ST_OK;
                                r_position <= '0;
                                r_out_rec  <= '0;
                            end
                        endcase
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.position        = r_position;
    assign o_rsp.entry_count     = r_entry_count;
    assign o_rsp.out_name_head   = r_out_rec.name_head;
    assign o_rsp.out_name_middle = r_out_rec.name_middle;
    assign o_rsp.out_name_tail   = r_out_rec.name_tail;
    assign o_rsp.out_population  = r_out_rec.population;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("Entry count exceeds the table size.");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_count == $past(r_count) + 1'b1))
        else $error("Insert did not advance the entry count by one.");

    a_take_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |-> $onehot(w_take))
        else $error("Insert did not select exactly one slot.");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.clr |=> (r_count == '0) && !w_link[0].valid)
        else $error("Clear left entries in the table.");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_FULL)) |-> (r_entry_count == COUNT_W'(CAPACITY)))
        else $error("Full status given while the table had room.");

endmodule
